[src/bilinear_upscale_wrap_defines.svh]
// Assertion macros for the files that check their own logic.
`ifndef BILINEAR_UPSCALE_WRAP_DEFINES_SVH
`define BILINEAR_UPSCALE_WRAP_DEFINES_SVH
`ifndef SYNTH
// Antecedent implies consequent in the same cycle.
`define BU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define BU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BU_ASSERT_NOW(lbl, ante, cons)
`define BU_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[src/bu_pkg.sv]
`timescale 1ns / 1ps
package bu_pkg;

    localparam int RowW   = 11;
    localparam int ColW   = 11;
    localparam int PixW   = 8;
    localparam int ValW   = 16;
    localparam int RowsW  = 9;
    localparam int ScaleW = 4;

    localparam logic [3:0] AddrRows  = 4'h0;
    localparam logic [3:0] AddrCols  = 4'h4;
    localparam logic [3:0] AddrScale = 4'h8;

    localparam logic FuncLoad = 1'b0;

    typedef struct packed {
        logic capture;
        logic load_wr;
        logic div_init;
        logic div_step;
        logic addr;
        logic rd_step;
        logic fdiv_init;
        logic fdiv_step;
        logic post;
    } bu_cmd_t;

    typedef struct packed {
        logic in_is_load;
        logic range_err;
        logic cnt_zero;
        logic rd_done;
        logic out_busy;
    } bu_sts_t;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_LOAD  = 8'b0000_0010,
        ST_CHECK = 8'b0000_0100,
        ST_DIV   = 8'b0000_1000,
        ST_ADDR  = 8'b0001_0000,
        ST_READ  = 8'b0010_0000,
        ST_FINIT = 8'b0100_0000,
        ST_FDIV  = 8'b1000_0000
    } bu_state_t;

endpackage

[src/bu_ram.sv]
`timescale 1ns / 1ps
module bu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/bu_ctrl.sv]
`timescale 1ns / 1ps
module bu_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  bu_pkg::bu_sts_t  sts,
    output bu_pkg::bu_cmd_t  cmd
);

    bu_pkg::bu_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bu_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // The result is posted from the final divide state or, for an out-of-range
    // read, from the check state once the output register is free.
    always_comb
    begin
        cmd        = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            bu_pkg::ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = sts.in_is_load ? bu_pkg::ST_LOAD : bu_pkg::ST_CHECK;
                end
            end
            bu_pkg::ST_LOAD:
            begin
                cmd.load_wr = 1'b1;
                state_next  = bu_pkg::ST_IDLE;
            end
            bu_pkg::ST_CHECK:
            begin
                if (sts.range_err)
                begin
                    if (!sts.out_busy)
                    begin
                        cmd.post   = 1'b1;
                        state_next = bu_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = bu_pkg::ST_DIV;
                end
            end
            bu_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.cnt_zero)
                begin
                    state_next = bu_pkg::ST_ADDR;
                end
            end
            bu_pkg::ST_ADDR:
            begin
                cmd.addr   = 1'b1;
                state_next = bu_pkg::ST_READ;
            end
            bu_pkg::ST_READ:
            begin
                cmd.rd_step = 1'b1;
                if (sts.rd_done)
                begin
                    state_next = bu_pkg::ST_FINIT;
                end
            end
            bu_pkg::ST_FINIT:
            begin
                cmd.fdiv_init = 1'b1;
                state_next    = bu_pkg::ST_FDIV;
            end
            bu_pkg::ST_FDIV:
            begin
                if (!sts.cnt_zero)
                begin
                    cmd.fdiv_step = 1'b1;
                end
                else
                begin
                    if (!sts.out_busy)
                    begin
                        cmd.post   = 1'b1;
                        state_next = bu_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = bu_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[src/bu_dp.sv]
`timescale 1ns / 1ps
module bu_dp #(
    parameter int MAX_ROWS  = 256,
    parameter int MAX_COLS  = 256,
    parameter int MAX_SCALE = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bu_pkg::bu_cmd_t               cmd,
    output bu_pkg::bu_sts_t               sts,
    input  logic [31:0]                   s_tdata,
    input  logic [0:0]                    s_tuser,
    input  logic [bu_pkg::RowsW-1:0]      cfg_rows,
    input  logic [bu_pkg::RowsW-1:0]      cfg_cols,
    input  logic [bu_pkg::ScaleW-1:0]     cfg_scale,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bu_pkg::ValW-1:0]       value,
    output logic                          error
);

    localparam int AW   = $clog2(MAX_ROWS * MAX_COLS);
    localparam int RCW  = $clog2(MAX_ROWS + 1);
    localparam int CCW  = $clog2(MAX_COLS + 1);
    localparam int SW   = $clog2(MAX_SCALE + 1);
    localparam int VW   = 2 * SW;
    localparam int ACW  = bu_pkg::PixW + VW;
    localparam int FDW  = ACW + 8;
    localparam int CW   = $clog2(FDW + 1);
    localparam int RW   = bu_pkg::RowW;
    localparam int CLW  = bu_pkg::ColW;

    // Captured item.
    logic [RW-1:0]           i_reg;
    logic [CLW-1:0]          j_reg;
    logic [bu_pkg::PixW-1:0] pix_reg;

    // Clamped configuration.
    logic [RCW-1:0] rows;
    logic [CCW-1:0] cols;
    logic [SW-1:0]  s;
    logic [VW-1:0]  s2;

    always_comb
    begin
        if (cfg_rows == '0)
            rows = RCW'(1);
        else if (32'(cfg_rows) > MAX_ROWS)
            rows = RCW'(MAX_ROWS);
        else
            rows = RCW'(cfg_rows);
        if (cfg_cols == '0)
            cols = CCW'(1);
        else if (32'(cfg_cols) > MAX_COLS)
            cols = CCW'(MAX_COLS);
        else
            cols = CCW'(cfg_cols);
        if (cfg_scale == '0)
            s = SW'(1);
        else if (32'(cfg_scale) > MAX_SCALE)
            s = SW'(MAX_SCALE);
        else
            s = SW'(cfg_scale);
        s2 = VW'(s) * VW'(s);
    end

    logic [RCW+SW-1:0] rows_lim;
    logic [CCW+SW-1:0] cols_lim;
    assign rows_lim = (RCW+SW)'(rows) * (RCW+SW)'(s);
    assign cols_lim = (CCW+SW)'(cols) * (CCW+SW)'(s);

    // Row and column dividers, one quotient bit a cycle.
    logic [RW-1:0]  qr_reg;
    logic [SW-1:0]  rr_reg;
    logic [CLW-1:0] qc_reg;
    logic [SW-1:0]  rc_reg;
    logic [SW:0]    tr, tc;
    logic           ger, gec;
    logic [CW-1:0]  cnt_reg;

    always_comb
    begin
        tr  = {rr_reg, qr_reg[RW-1]};
        tc  = {rc_reg, qc_reg[CLW-1]};
        ger = tr >= {1'b0, s};
        gec = tc >= {1'b0, s};
    end

    // Neighbor addresses and weights.
    logic [RW:0]    r_inc;
    logic [CLW:0]   c_inc;
    logic [RW-1:0]  r1;
    logic [CLW-1:0] c1;
    logic [SW-1:0]  fr_inv, fc_inv;

    always_comb
    begin
        r_inc  = {1'b0, qr_reg} + 1'b1;
        c_inc  = {1'b0, qc_reg} + 1'b1;
        r1     = (32'(r_inc) >= 32'(rows)) ? '0 : r_inc[RW-1:0];
        c1     = (32'(c_inc) >= 32'(cols)) ? '0 : c_inc[CLW-1:0];
        fr_inv = s - rr_reg;
        fc_inv = s - rc_reg;
    end

    logic [AW-1:0] base0_reg, base1_reg, col0_reg, col1_reg;
    logic [VW-1:0] w_reg [4];
    logic [ACW-1:0] acc_reg;

    // Frame store.
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr, ram_raddr;
    logic [bu_pkg::PixW-1:0] ram_rdata;
    logic                    load_ok;

    assign load_ok   = (32'(i_reg) < MAX_ROWS) && (32'(j_reg) < MAX_COLS);
    assign ram_we    = cmd.load_wr && load_ok;
    assign ram_waddr = AW'(i_reg) * AW'(MAX_COLS) + AW'(j_reg);

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    ram_raddr = base0_reg + col0_reg;
            2'd1:    ram_raddr = base0_reg + col1_reg;
            2'd2:    ram_raddr = base1_reg + col0_reg;
            default: ram_raddr = base1_reg + col1_reg;
        endcase
    end

    bu_ram #(
        .WIDTH (bu_pkg::PixW),
        .DEPTH (MAX_ROWS * MAX_COLS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (pix_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [1:0]     wsel;
    logic [ACW-1:0] prod;
    assign wsel = cnt_reg[1:0] - 2'd1;
    assign prod = ACW'(ram_rdata) * ACW'(w_reg[wsel]);

    // Final divide of the scaled sum by s squared.
    logic [FDW-1:0] fq_reg;
    logic [VW-1:0]  frem_reg;
    logic [VW:0]    tf;
    logic           gef;

    always_comb
    begin
        tf  = {frem_reg, fq_reg[FDW-1]};
        gef = tf >= {1'b0, s2};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            j_reg   <= s_tdata[RW +: CLW];
            i_reg   <= s_tdata[0 +: RW];
            pix_reg <= s_tdata[RW+CLW +: bu_pkg::PixW];
        end
        if (cmd.div_init)
        begin
            qr_reg <= i_reg;
            rr_reg <= '0;
            qc_reg <= j_reg;
            rc_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            qr_reg <= {qr_reg[RW-2:0], ger};
            rr_reg <= ger ? SW'(tr - {1'b0, s}) : tr[SW-1:0];
            qc_reg <= {qc_reg[CLW-2:0], gec};
            rc_reg <= gec ? SW'(tc - {1'b0, s}) : tc[SW-1:0];
        end
        if (cmd.addr)
        begin
            base0_reg <= AW'(qr_reg) * AW'(MAX_COLS);
            base1_reg <= AW'(r1) * AW'(MAX_COLS);
            col0_reg  <= AW'(qc_reg);
            col1_reg  <= AW'(c1);
            w_reg[0]  <= VW'(fr_inv) * VW'(fc_inv);
            w_reg[1]  <= VW'(fr_inv) * VW'(rc_reg);
            w_reg[2]  <= VW'(rr_reg) * VW'(fc_inv);
            w_reg[3]  <= VW'(rr_reg) * VW'(rc_reg);
            acc_reg   <= '0;
        end
        else if (cmd.rd_step && cnt_reg != '0)
        begin
            acc_reg <= acc_reg + prod;
        end
        if (cmd.fdiv_init)
        begin
            fq_reg   <= {acc_reg, 8'h00};
            frem_reg <= '0;
        end
        else if (cmd.fdiv_step)
        begin
            fq_reg   <= {fq_reg[FDW-2:0], gef};
            frem_reg <= gef ? VW'(tf - {1'b0, s2}) : tf[VW-1:0];
        end
        if (cmd.post)
        begin
            value <= sts.range_err ? '0 : fq_reg[bu_pkg::ValW-1:0];
            error <= sts.range_err;
        end
    end

    // Step counter shared by the dividers and the neighbor reads.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            m_tvalid <= 1'b0;
        end
        else
        begin
            if (cmd.div_init)
                cnt_reg <= CW'(RW - 1);
            else if (cmd.fdiv_init)
                cnt_reg <= CW'(FDW);
            else if (cmd.addr)
                cnt_reg <= '0;
            else if (cmd.rd_step)
                cnt_reg <= cnt_reg + 1'b1;
            else if ((cmd.div_step || cmd.fdiv_step) && cnt_reg != '0)
                cnt_reg <= cnt_reg - 1'b1;
            if (cmd.post)
                m_tvalid <= 1'b1;
            else if (m_tready)
                m_tvalid <= 1'b0;
        end
    end

    always_comb
    begin
        sts.in_is_load = (s_tuser[0] == bu_pkg::FuncLoad);
        sts.range_err  = (32'(i_reg) >= 32'(rows_lim)) || (32'(j_reg) >= 32'(cols_lim));
        sts.cnt_zero   = (cnt_reg == '0);
        sts.rd_done    = (cnt_reg == CW'(4));
        sts.out_busy   = m_tvalid && !m_tready;
    end

endmodule

[src/bilinear_upscale_wrap.sv]
`timescale 1ns / 1ps
// Load transaction: written to the frame store in the cycle after acceptance.
// Read transaction: from acceptance to result come the range check, the row and column
// divider steps, address setup, the frame store reads, divide setup, the final divide
// steps and the post; a new transaction is accepted only once the result is posted.
// An out-of-range read posts its error result from the check state once the output register is free.
// rst_n is asynchronous, active low: registers return to 256/256/2; store contents are undefined.
module bilinear_upscale_wrap #(
    parameter int MAX_ROWS  = 256,
    parameter int MAX_COLS  = 256,
    parameter int MAX_SCALE = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream. tdata: row[10:0], col[21:11], pixel[29:22], zero fill.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // tuser: func[0] (0 = load pixel, 1 = read interpolated pixel).
    input  logic [0:0]  s_tuser,
    // Output stream. tdata: value[15:0], unsigned 8.8.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    // tuser: error[0].
    output logic [0:0]  m_tuser,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "bilinear_upscale_wrap_defines.svh"

    logic [bu_pkg::RowsW-1:0]  rows_reg;
    logic [bu_pkg::RowsW-1:0]  cols_reg;
    logic [bu_pkg::ScaleW-1:0] scale_reg;
    logic                      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Registers keep the raw written value; the datapath saturates on use.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= bu_pkg::RowsW'(256);
            cols_reg  <= bu_pkg::RowsW'(256);
            scale_reg <= bu_pkg::ScaleW'(2);
        end
        else if (cfg_wr)
        begin
            case (paddr)
                bu_pkg::AddrRows:  rows_reg  <= pwdata[bu_pkg::RowsW-1:0];
                bu_pkg::AddrCols:  cols_reg  <= pwdata[bu_pkg::RowsW-1:0];
                bu_pkg::AddrScale: scale_reg <= pwdata[bu_pkg::ScaleW-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            bu_pkg::AddrRows:  prdata = 32'(rows_reg);
            bu_pkg::AddrCols:  prdata = 32'(cols_reg);
            bu_pkg::AddrScale: prdata = 32'(scale_reg);
            default:           prdata = '0;
        endcase
    end

    bu_pkg::bu_cmd_t cmd;
    bu_pkg::bu_sts_t sts;
    logic            err_bit;

    // The controller sequences capture, load writes, divide, neighbor reads and the final divide.
    bu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bu_dp #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .MAX_SCALE (MAX_SCALE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_rows  (rows_reg),
        .cfg_cols  (cols_reg),
        .cfg_scale (scale_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .value     (m_tdata),
        .error     (err_bit)
    );

    assign m_tuser = err_bit;

    // Every accepted transaction makes the block busy, so s_tready drops after acceptance.
    `BU_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    // An error result always carries a zero value.
    `BU_ASSERT_NOW(a_err_zero, m_tvalid && m_tuser[0], m_tdata == 16'h0000)
    // The interpolated value never exceeds the largest pixel in 8.8 form.
    `BU_ASSERT_NOW(a_val_max, m_tvalid, m_tdata <= 16'hFF00)

endmodule

[dv/bilinear_upscale_wrap_chk.sv]
`timescale 1ns / 1ps
module bilinear_upscale_wrap_chk (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [0:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fails,
    output int          pending
);

    localparam int StoreCols = 256;
    localparam int StoreRows = 256;
    localparam int ScaleMax  = 8;

    typedef struct packed {
        logic [bu_pkg::ValW-1:0] value;
        logic                    err;
    } pix_result_t;

    logic [bu_pkg::PixW-1:0]   image_mem [0:StoreRows*StoreCols-1];
    logic [bu_pkg::RowsW-1:0]  rows_reg;
    logic [bu_pkg::RowsW-1:0]  cols_reg;
    logic [bu_pkg::ScaleW-1:0] scale_reg;
    pix_result_t               upscaled_q[$];

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Bilinear weighting with the row and column neighbours wrapping to zero.
    function automatic pix_result_t upscale_pixel(int i, int j);
        pix_result_t res;
        int          nr, nc, s, r, c, fr, fc, r1, c1;
        longint      acc;
        nr = clamp(rows_reg, 1, StoreRows);
        nc = clamp(cols_reg, 1, StoreCols);
        s  = clamp(scale_reg, 1, ScaleMax);
        res = '0;
        if (i >= nr * s || j >= nc * s)
        begin
            res.err = 1'b1;
            return res;
        end
        r  = i / s;
        fr = i % s;
        c  = j / s;
        fc = j % s;
        r1 = (r + 1 >= nr) ? 0 : r + 1;
        c1 = (c + 1 >= nc) ? 0 : c + 1;
        acc = longint'((s - fr) * (s - fc)) * image_mem[r * StoreCols + c]
            + longint'((s - fr) * fc) * image_mem[r * StoreCols + c1]
            + longint'(fr * (s - fc)) * image_mem[r1 * StoreCols + c]
            + longint'(fr * fc) * image_mem[r1 * StoreCols + c1];
        res.value = bu_pkg::ValW'((acc * 256) / (s * s));
        return res;
    endfunction

    task automatic report(string what, int got, int want);
        $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
        fails++;
    endtask

    initial fails = 0;
    assign pending = upscaled_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        pix_result_t want;
        int          i, j;
        if (!rst_n)
        begin
            rows_reg  <= 9'd256;
            cols_reg  <= 9'd256;
            scale_reg <= 4'd2;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == bu_pkg::AddrRows)
                    rows_reg <= pwdata[bu_pkg::RowsW-1:0];
                else if (paddr == bu_pkg::AddrCols)
                    cols_reg <= pwdata[bu_pkg::RowsW-1:0];
                else if (paddr == bu_pkg::AddrScale)
                    scale_reg <= pwdata[bu_pkg::ScaleW-1:0];
            end
            if (s_tvalid && s_tready)
            begin
                i = s_tdata[10:0];
                j = s_tdata[21:11];
                if (s_tuser[0] == bu_pkg::FuncLoad)
                begin
                    if (i < StoreRows && j < StoreCols)
                        image_mem[i * StoreCols + j] = s_tdata[29:22];
                end
                else
                    upscaled_q.push_back(upscale_pixel(i, j));
            end
            if (m_tvalid && m_tready)
            begin
                if (upscaled_q.size() == 0)
                    report("unexpected result, value", m_tdata, -1);
                else
                begin
                    want = upscaled_q.pop_front();
                    if (m_tdata !== want.value)
                        report("value", m_tdata, want.value);
                    if (m_tuser[0] !== want.err)
                        report("error flag", m_tuser[0], want.err);
                end
            end
        end
    end

endmodule

[dv/tb_bilinear_upscale_wrap.sv]
`timescale 1ns / 1ps
// Stimulus and verdict for the bilinear upscaler. A checker beside the block
// watches both streams and the configuration port and scores every result.
module tb_bilinear_upscale_wrap;

    // Function code for a read and an address past the register list.
    localparam logic       FuncRead   = ~bu_pkg::FuncLoad;
    localparam logic [3:0] AddrUnused = 4'hC;
    localparam int         CycleLimit = 1000000;
    localparam int         HoldCycles = 600;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fails;
    int          pending;

    // Mirror of the effective geometry, used only to aim the stimulus.
    int eff_rows, eff_cols, eff_scale;
    // Which store entries hold a pixel, so that a read never touches an empty one.
    bit loaded [0:65535];
    int burst_left;
    int n_loads, n_reads, n_oob, n_settings;
    int cycles;
    bit hold_req;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    bilinear_upscale_wrap i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    bilinear_upscale_wrap_chk i_chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pready   (pready),
        .fails    (fails),
        .pending  (pending)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: switches between stall patterns, and on request holds off for
    // a long stretch so that the block backs up and drops s_tready.
    initial
    begin
        int mode, left, k, tick;
        m_tready = 1'b0;
        left = 0;
        tick = 0;
        mode = 0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                for (k = 0; k < HoldCycles; k++)
                    @(negedge clk);
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    left = $urandom_range(64, 256);
                end
                left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= $urandom_range(0, 1);
                    default: m_tready <= ((tick % 5) < 2);
                endcase
            end
        end
    end

    // One configuration write: setup phase, then access phase.
    task automatic reg_write(logic [3:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Writes all three registers and keeps the saturated values for aiming reads.
    task automatic set_geometry(logic [31:0] rows_raw, logic [31:0] cols_raw,
                                logic [31:0] scale_raw);
        reg_write(bu_pkg::AddrRows, rows_raw);
        reg_write(bu_pkg::AddrCols, cols_raw);
        reg_write(bu_pkg::AddrScale, scale_raw);
        eff_rows  = clamp(rows_raw[8:0], 1, 256);
        eff_cols  = clamp(cols_raw[8:0], 1, 256);
        eff_scale = clamp(scale_raw[3:0], 1, 8);
        n_settings++;
    endtask

    // Offers one transaction. Valid stays high across a burst; this task drops it
    // only for the random gap in front of the next burst.
    task automatic push(logic func, int row, int col, int pixel);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {2'b00, pixel[7:0], col[10:0], row[10:0]};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        burst_left--;
        if (func == bu_pkg::FuncLoad)
        begin
            n_loads++;
            if (row < 256 && col < 256)
                loaded[row * 256 + col] = 1'b1;
        end
        else
            n_reads++;
    endtask

    task automatic load_if_empty(int r, int c);
        if (!loaded[r * 256 + c])
            push(bu_pkg::FuncLoad, r, c, $urandom_range(0, 255));
    endtask

    // Reads an output pixel, first filling any of its four neighbours that
    // have never been loaded.
    task automatic read_pixel(int i, int j);
        int r, c, r1, c1;
        if (i < eff_rows * eff_scale && j < eff_cols * eff_scale)
        begin
            r  = i / eff_scale;
            c  = j / eff_scale;
            r1 = (r + 1 >= eff_rows) ? 0 : r + 1;
            c1 = (c + 1 >= eff_cols) ? 0 : c + 1;
            load_if_empty(r, c);
            load_if_empty(r, c1);
            load_if_empty(r1, c);
            load_if_empty(r1, c1);
        end
        else
            n_oob++;
        push(FuncRead, i, j, $urandom_range(0, 255));
    endtask

    // Idle point between settings: everything returned, then the latency pause
    // in case a load is still being written.
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    // Random traffic: mostly in-range reads, some out-of-range reads and some
    // stray loads, including loads that fall outside the store.
    task automatic random_phase(int count);
        int k, pick, hi_r, hi_c;
        for (k = 0; k < count; k++)
        begin
            hi_r = eff_rows * eff_scale;
            hi_c = eff_cols * eff_scale;
            pick = $urandom_range(0, 99);
            if (pick < 12)
                push(bu_pkg::FuncLoad, $urandom_range(0, 2047), $urandom_range(0, 2047),
                     $urandom_range(0, 255));
            else if (pick < 27 && hi_r < 2048)
                read_pixel($urandom_range(hi_r, 2047), $urandom_range(0, 2047));
            else if (pick < 27 && hi_c < 2048)
                read_pixel($urandom_range(0, hi_r - 1), $urandom_range(hi_c, 2047));
            else
                read_pixel($urandom_range(0, hi_r - 1), $urandom_range(0, hi_c - 1));
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        cycles     = 0;
        hold_req   = 1'b0;
        burst_left = 0;
        n_loads    = 0;
        n_reads    = 0;
        n_oob      = 0;
        n_settings = 1;
        eff_rows   = 256;
        eff_cols   = 256;
        eff_scale  = 2;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset geometry of 256 by 256, scale 2.
        push(bu_pkg::FuncLoad, 0, 0, 255);
        push(bu_pkg::FuncLoad, 0, 1, 0);
        push(bu_pkg::FuncLoad, 1, 0, 255);
        push(bu_pkg::FuncLoad, 1, 1, 255);
        read_pixel(0, 0);
        read_pixel(1, 1);
        read_pixel(0, 1);
        // Bottom-right corner: both neighbours wrap back to row and column zero.
        read_pixel(511, 511);
        read_pixel(512, 0);
        read_pixel(0, 2047);
        read_pixel(2047, 2047);
        // Loads beyond the store are dropped; the following read must not see them.
        push(bu_pkg::FuncLoad, 2047, 5, 170);
        push(bu_pkg::FuncLoad, 300, 2047, 85);
        push(bu_pkg::FuncLoad, 255, 255, 255);
        read_pixel(510, 510);
        settle();

        // Saturation: zero clamps up to one, oversize values clamp down.
        set_geometry(32'd0, 32'd0, 32'd0);
        reg_write(AddrUnused, 32'hFFFF_FFFF);
        read_pixel(0, 0);
        read_pixel(1, 0);
        read_pixel(0, 1);
        settle();
        set_geometry(32'h0000_012C, 32'hFFFF_FFFF, 32'h0000_000F);
        read_pixel(2047, 2047);
        read_pixel(2047, 0);
        read_pixel(1029, 1366);
        random_phase(40);
        settle();

        set_geometry(32'd1, 32'd256, 32'd8);
        random_phase(35);
        settle();

        set_geometry(32'hFFFF_FE03, 32'd5, 32'd3);
        random_phase(40);
        // Long output hold-off while the sender keeps offering.
        hold_req = 1'b1;
        random_phase(30);
        settle();

        set_geometry(32'd256, 32'd1, 32'd1);
        random_phase(30);
        settle();

        set_geometry($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 8));
        random_phase(45);
        settle();

        set_geometry(32'd7, 32'd4, 32'd2);
        random_phase(30);
        settle();

        $display("Covered %0d loads and %0d reads (%0d outside the image) over %0d settings,",
                 n_loads, n_reads, n_oob, n_settings);
        $display("with bursty input, stalled output and one long output hold-off.");
        if (fails == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
